@@ rtl/ocn_pkg.sv @@
package ocn_pkg;

    // Fixed field widths of the two channels and the configuration port.
    localparam int SIG_W = 32;

    typedef logic [SIG_W-1:0] t_sig;

    typedef struct packed {
        t_sig sig;
        logic last;
    } t_in_item;

    typedef struct packed {
        t_sig sig_res;
        logic last_res;
        logic is_empty;
        logic overflow;
    } t_out_item;

    // Controller to datapath.
    typedef struct packed {
        logic load;       // insert the incoming literal into the sorted store
        logic emit_true;  // emit the single true code and close the clause
        logic drain;      // walk the store by one entry, or close when empty
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic taut;       // clause already known to be a tautology
        logic cnt_zero;   // no entries left in the store
    } t_stat;

endpackage

@@ rtl/ocn_ctrl.sv @@
module ocn_ctrl
    import ocn_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  logic  i_last,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DRAIN
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.load = i_start;
                if (i_start && i_last) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_stat.taut) begin
                    o_cmd.emit_true = 1'b1;
                    n_state         = ST_IDLE;
                end else begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                o_cmd.drain = 1'b1;
                if (i_stat.cnt_zero) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

@@ rtl/ocn_dpath.sv @@
module ocn_dpath
    import ocn_pkg::*;
#(
    parameter int MAX_SIGS = 32,
    parameter int SIG_BITS = 32
)(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  t_sig      i_cfg_wdata,
    input  t_in_item  i_item,
    input  t_cmd      i_cmd,
    output t_stat     o_stat,
    output logic      o_res_stb,
    output t_out_item o_item
);

    // Codes wider than the input field cannot occur.
    localparam int SW = (SIG_BITS > SIG_W) ? SIG_W : SIG_BITS;
    localparam int CW = $clog2(MAX_SIGS + 1);

    logic [SW-1:0] r_store [MAX_SIGS];
    logic [SW-1:0] n_store [MAX_SIGS];
    logic [CW-1:0] r_cnt;
    logic [SW-1:0] r_true;
    logic          r_taut;
    logic          r_ovf;
    logic [SW-1:0] r_prev;
    logic          r_prev_vld;
    logic [SW-1:0] r_pend;
    logic          r_pend_vld;
    logic          r_stb;
    t_out_item     r_out;

    logic [SW-1:0]       v;
    logic [SW-1:0]       f_code;
    logic [SW-1:0]       head;
    logic [MAX_SIGS-1:0] le;
    logic [MAX_SIGS-1:0] pair;
    logic                full;
    logic                hit;
    logic                skip;

    assign v      = i_item.sig[SW-1:0];
    assign f_code = r_true | SW'(1);
    assign head   = r_store[0];
    assign full   = (r_cnt == CW'(MAX_SIGS));
    assign skip   = (r_prev_vld && head == r_prev) || head == f_code;

    // Compare the new literal against every stored entry in parallel.
    always_comb begin
        for (int i = 0; i < MAX_SIGS; i++) begin
            le[i]   = (CW'(i) < r_cnt) && (r_store[i] <= v);
            pair[i] = (CW'(i) < r_cnt) && (r_store[i][SW-1:1] == v[SW-1:1])
                      && (r_store[i][0] != v[0]);
        end
        hit = (v == r_true) || (|pair);
    end

    // Insert in sorted position, or shift down by one entry while draining.
    always_comb begin
        for (int i = 0; i < MAX_SIGS; i++) begin
            n_store[i] = r_store[i];
        end
        if (i_cmd.load) begin
            n_store[0] = le[0] ? r_store[0] : v;
            for (int i = 1; i < MAX_SIGS; i++) begin
                n_store[i] = le[i] ? r_store[i] : (le[i-1] ? v : r_store[i-1]);
            end
        end else if (i_cmd.drain) begin
            for (int i = 0; i < MAX_SIGS - 1; i++) begin
                n_store[i] = r_store[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && !full) begin
            for (int i = 0; i < MAX_SIGS; i++) begin
                r_store[i] <= n_store[i];
            end
        end else if (i_cmd.drain) begin
            for (int i = 0; i < MAX_SIGS; i++) begin
                r_store[i] <= n_store[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_true     <= '0;
            r_cnt      <= '0;
            r_taut     <= 1'b0;
            r_ovf      <= 1'b0;
            r_prev_vld <= 1'b0;
            r_pend_vld <= 1'b0;
            r_stb      <= 1'b0;
        end else begin
            r_stb <= 1'b0;
            if (i_cfg_we) begin
                r_true <= {i_cfg_wdata[SW-1:1], 1'b0};
            end
            if (i_cmd.load) begin
                if (full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_cnt  <= r_cnt + CW'(1);
                    r_taut <= r_taut | hit;
                end
            end
            if (i_cmd.emit_true) begin
                r_stb          <= 1'b1;
                r_out.sig_res  <= t_sig'(r_true);
                r_out.last_res <= 1'b1;
                r_out.is_empty <= 1'b0;
                r_out.overflow <= r_ovf;
                r_cnt          <= '0;
                r_taut         <= 1'b0;
                r_ovf          <= 1'b0;
            end
            if (i_cmd.drain) begin
                if (r_cnt != '0) begin
                    // Hold one pending literal so the final one can carry last.
                    r_cnt      <= r_cnt - CW'(1);
                    r_prev     <= head;
                    r_prev_vld <= 1'b1;
                    if (!skip) begin
                        r_pend     <= head;
                        r_pend_vld <= 1'b1;
                        if (r_pend_vld) begin
                            r_stb          <= 1'b1;
                            r_out.sig_res  <= t_sig'(r_pend);
                            r_out.last_res <= 1'b0;
                            r_out.is_empty <= 1'b0;
                            r_out.overflow <= r_ovf;
                        end
                    end
                end else begin
                    r_stb          <= 1'b1;
                    r_out.sig_res  <= r_pend_vld ? t_sig'(r_pend) : '0;
                    r_out.last_res <= 1'b1;
                    r_out.is_empty <= !r_pend_vld;
                    r_out.overflow <= r_ovf;
                    r_taut         <= 1'b0;
                    r_ovf          <= 1'b0;
                    r_prev_vld     <= 1'b0;
                    r_pend_vld     <= 1'b0;
                end
            end
        end
    end

    assign o_stat.taut     = r_taut;
    assign o_stat.cnt_zero = (r_cnt == '0);
    assign o_res_stb       = r_stb;
    assign o_item          = r_out;

endmodule

@@ rtl/or_clause_normalizer.sv @@
// Channel  | Handshake                | Payload              | Direction
// ---------+--------------------------+----------------------+----------
// literal  | start high, busy low     | i_item (t_in_item)   | in
// result   | o_res_stb, one cycle     | o_item (t_out_item)  | out
// config   | i_cfg_we                 | i_cfg_wdata          | in
//
// A literal that is not last is inserted; busy stays low.
// A last literal is inserted, then checked for a tautology, then the store is
// walked in ascending order and the clause is closed.
// A tautology closes after the check cycle with the single true code.
// Reset is synchronous and empties the store; the receiver cannot stall.
module or_clause_normalizer
    import ocn_pkg::*;
#(
    parameter int MAX_SIGS = 32,
    parameter int SIG_BITS = 32
)(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output logic      o_res_stb,
    output t_out_item o_item,
    input  logic      i_cfg_we,
    input  t_sig      i_cfg_wdata
);

    t_cmd  cmd;
    t_stat stat;

    // Sequence load, tautology check and drain of each clause.
    ocn_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_last  (i_item.last),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // Hold the sorted store, the tautology flag and the result register.
    ocn_dpath #(
        .MAX_SIGS (MAX_SIGS),
        .SIG_BITS (SIG_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (i_item),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_res_stb   (o_res_stb),
        .o_item      (o_item)
    );

endmodule

@@ rtl/ocn_checker.sv @@
module ocn_checker
    import ocn_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input logic      busy,
    input t_in_item  i_item,
    input logic      o_res_stb,
    input t_out_item o_item
);

    // A last literal always starts the closing work.
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_item.last |=> busy)
        else $error("last literal did not raise busy");

    // A literal that is not last produces nothing and keeps the block open.
    a_mid_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && !i_item.last |=> !busy && !o_res_stb)
        else $error("non-final literal caused a result or busy");

    // An empty clause is a single zero code that closes the clause.
    a_empty_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_stb && o_item.is_empty |-> o_item.last_res && o_item.sig_res == '0)
        else $error("empty result malformed");

    // Nothing follows the closing transfer of a clause.
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_stb && o_item.last_res |=> !o_res_stb)
        else $error("result after closing transfer");

    // More of the clause is still to come while busy.
    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_stb && !o_item.last_res |-> busy)
        else $error("open clause transfer while idle");

endmodule

bind or_clause_normalizer ocn_checker u_ocn_checker (.*);

@@ test/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ocn_pkg::*;

    localparam int NSIG        = 32;    // store depth of the instance
    localparam int STALL_LIMIT = 2000;  // cycles with no transfer before giving up

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      start       = 1'b0;
    t_in_item  i_item      = '0;
    logic      i_cfg_we    = 1'b0;
    t_sig      i_cfg_wdata = '0;
    logic      busy;
    logic      o_res_stb;
    t_out_item o_item;

    or_clause_normalizer #(
        .MAX_SIGS(NSIG),
        .SIG_BITS(SIG_W)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_res_stb  (o_res_stb),
        .o_item     (o_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    // 8 ns clock, low phase first.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Literals waiting to be driven, filled by the sequencer below.
    t_in_item  pending[$];
    // Normalized clause items still owed by the block, oldest first.
    t_out_item norm_out[$];

    // Shadow copy of the block: sorted literal store, overflow flag, true code.
    t_sig      lit_store[$];
    logic      ovf_seen    = 1'b0;
    t_sig      true_code_m = '0;

    int        errors      = 0;
    bit        bursty      = 1'b0;  // no gaps between transfers while set
    int        gap_left    = 0;

    task automatic flag(input string msg);
        errors++;
        $display("%0t: %s", $time, msg);
    endtask

    // Fold one accepted literal into the shadow store. On the last literal of
    // a clause, compute the normalized clause and queue its items.
    task automatic absorb_literal(input t_in_item it);
        t_sig uniq[$];
        t_sig t_code;
        t_sig f_code;
        int   pos;
        int   kept;
        bit   taut;
        t_code = true_code_m & ~t_sig'(1);  // bit 0 of the register is ignored
        f_code = t_code | t_sig'(1);
        taut   = 1'b0;
        kept   = 0;
        // Drop the literal once the store is full, but remember that we did.
        if (lit_store.size() >= NSIG) begin
            ovf_seen = 1'b1;
        end else begin
            pos = lit_store.size();
            while (pos > 0 && lit_store[pos-1] > it.sig)
                pos--;
            lit_store.insert(pos, it.sig);
        end
        if (it.last) begin
            foreach (lit_store[i])
                if (uniq.size() == 0 || uniq[uniq.size()-1] != lit_store[i])
                    uniq.push_back(lit_store[i]);
            // Tautology: constant true present, or a literal next to its complement.
            foreach (uniq[i]) begin
                if (uniq[i] == t_code)
                    taut = 1'b1;
                if (i > 0 && uniq[i-1][SIG_W-1:1] == uniq[i][SIG_W-1:1])
                    taut = 1'b1;
            end
            if (taut) begin
                norm_out.push_back({t_code, 1'b1, 1'b0, ovf_seen});
            end else begin
                // Drop constant false, keep everything else in ascending order.
                foreach (uniq[i])
                    if (uniq[i] != f_code) begin
                        norm_out.push_back({uniq[i], 1'b0, 1'b0, ovf_seen});
                        kept++;
                    end
                if (kept == 0)
                    norm_out.push_back({t_sig'(0), 1'b1, 1'b1, ovf_seen});
                else
                    norm_out[norm_out.size()-1].last_res = 1'b1;
            end
            lit_store.delete();
            ovf_seen = 1'b0;
        end
    endtask

    // Mostly short gaps, a few long ones; none at all in burst phases.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (bursty || r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // Driver: hold the literal while busy, advance on transfer, idle at random.
    always @(posedge i_clk) begin
        logic     nxt_start;
        t_in_item nxt_item;
        nxt_start = start;
        nxt_item  = i_item;
        if (!i_rst_n) begin
            nxt_start = 1'b0;
            gap_left  = 0;
        end else begin
            if (start && !busy) begin
                absorb_literal(i_item);
                nxt_start = 1'b0;
                gap_left  = pick_gap();
            end
            if (!nxt_start) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending.size() > 0) begin
                    nxt_item  = pending.pop_front();
                    nxt_start = 1'b1;
                end
            end
        end
        start  <= nxt_start;
        i_item <= nxt_item;
    end

    // Monitor: every strobe is a transfer; check it against the oldest item owed.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_res_stb) begin
            if (norm_out.size() == 0) begin
                flag($sformatf("unexpected result: expected none, got %h", o_item));
            end else begin
                want = norm_out.pop_front();
                if (o_item.sig_res !== want.sig_res)
                    flag($sformatf("sig_res: expected %h, got %h",
                                   want.sig_res, o_item.sig_res));
                if (o_item.last_res !== want.last_res)
                    flag($sformatf("last_res: expected %b, got %b (sig_res %h)",
                                   want.last_res, o_item.last_res, want.sig_res));
                if (o_item.is_empty !== want.is_empty)
                    flag($sformatf("is_empty: expected %b, got %b (sig_res %h)",
                                   want.is_empty, o_item.is_empty, want.sig_res));
                if (o_item.overflow !== want.overflow)
                    flag($sformatf("overflow: expected %b, got %b (sig_res %h)",
                                   want.overflow, o_item.overflow, want.sig_res));
            end
        end
    end

    // Watchdog: give up after a long stretch with no transfer on either side.
    initial begin : watchdog
        int idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((start && !busy) || o_res_stb)
                idle = 0;
            else
                idle++;
        end
        $display("tb: errors");
        $finish;
    end

    // Wait until every literal is taken and every result is in, then let the
    // block run out its walk and closing cycles before touching the register.
    task automatic settle();
        while (pending.size() != 0 || start || norm_out.size() != 0)
            @(negedge i_clk);
        repeat (NSIG + 8) @(posedge i_clk);
    endtask

    task automatic write_true_code(input t_sig v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        true_code_m = v;
    endtask

    task automatic push_lit(input t_sig s, input logic l);
        pending.push_back({s, l});
    endtask

    // Queue one clause of random literals. Bias toward true, false, repeats
    // and complements so that tautologies and duplicate removal come up often.
    task automatic queue_clause(input int len);
        t_sig lits[$];
        t_sig t_code;
        t_sig s;
        int   r;
        t_code = true_code_m & ~t_sig'(1);
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(0, 99);
            if (r < 4)
                s = t_code;
            else if (r < 10)
                s = t_code | t_sig'(1);
            else if (r < 22 && lits.size() > 0)
                s = lits[$urandom_range(0, lits.size() - 1)];
            else if (r < 28 && lits.size() > 0)
                s = lits[$urandom_range(0, lits.size() - 1)] ^ t_sig'(1);
            else if (r < 55)
                s = t_sig'($urandom_range(0, 15));
            else if (r < 60)
                s = t_code ^ t_sig'($urandom_range(2, 7));
            else if (r < 64)
                s = $urandom_range(0, 1) ? '1 : '0;
            else
                s = $urandom();
            lits.push_back(s);
            push_lit(s, i == len - 1);
        end
    endtask

    // Sequencer: reset, directed clauses, then random phases under several
    // true codes, pausing for the block to drain between phases.
    initial begin
        t_sig cfg_vals[6];
        int   queued;
        int   len;
        int   r;
        cfg_vals[0] = 32'h0000_0000;
        cfg_vals[1] = 32'hFFFF_FFFE;
        cfg_vals[2] = 32'hFFFF_FFFF;   // odd code, bit 0 must be ignored
        cfg_vals[3] = 32'h0000_0007;
        cfg_vals[4] = $urandom();
        cfg_vals[5] = $urandom() | 32'h1;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: true is 0x10, false is 0x11.
        write_true_code(32'h0000_0010);
        @(negedge i_clk);
        push_lit(32'h0000_0000, 1'b1);               // lowest code alone
        push_lit(32'hFFFF_FFFF, 1'b1);               // highest code alone
        push_lit(32'h0000_0011, 1'b1);               // only false: empty clause
        push_lit(32'h0000_0010, 1'b1);               // constant true
        push_lit(32'h0000_0010, 1'b0);               // true with false
        push_lit(32'h0000_0011, 1'b1);
        push_lit(32'h0000_0025, 1'b0);               // literal with its complement
        push_lit(32'h0000_0024, 1'b1);
        push_lit(32'h0000_0007, 1'b0);               // repeats and false dropped
        push_lit(32'h0000_0003, 1'b0);
        push_lit(32'h0000_0007, 1'b0);
        push_lit(32'h0000_0011, 1'b0);
        push_lit(32'h0000_0003, 1'b1);
        push_lit(32'h8000_0000, 1'b0);               // unsorted wide codes
        push_lit(32'h7FFF_FFFE, 1'b0);
        push_lit(32'h0000_0005, 1'b1);
        settle();

        for (int ph = 0; ph < 6; ph++) begin
            write_true_code(cfg_vals[ph]);
            @(negedge i_clk);
            bursty = (ph == 2 || ph == 5);
            queued = 0;
            while (queued < 66) begin
                r = $urandom_range(0, 99);
                if (r < 65)
                    len = $urandom_range(1, 4);
                else if (r < 88)
                    len = $urandom_range(5, 10);
                else if (r < 95)
                    len = $urandom_range(NSIG - 4, NSIG);        // fill the store
                else
                    len = $urandom_range(NSIG + 1, NSIG + 8);    // overflow
                queue_clause(len);
                queued += len;
            end
            settle();
        end

        if (errors == 0 && norm_out.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

@@ or_clause_normalizer.f @@
rtl/ocn_pkg.sv
rtl/ocn_ctrl.sv
rtl/ocn_dpath.sv
rtl/or_clause_normalizer.sv
rtl/ocn_checker.sv
test/tb.sv
